/* hdl/sldt_pkg.sv */
// Shared types and constants for the segmented line distance transform.
// No dependencies.
package sldt_pkg;

   localparam int LABEL_W = 16;
   localparam int DIST_W  = 32;
   localparam int VOX_W   = 16;
   localparam int HGT_W   = 48;
   localparam int DEN_W   = 24;
   localparam int CSR_W   = 16;

   localparam logic [DIST_W-1:0] DIST_INF = '1;
   localparam logic [VOX_W-1:0]  VOX_RESET = 16'd256;

   localparam logic [0:0] CSR_VOXEL_SIZE = 1'b0;
   localparam logic [0:0] CSR_EDGE_BOUND = 1'b1;

   typedef struct packed {
      logic             start;
      logic [HGT_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [HGT_W-1:0] quo;
      logic             rem_nz;
   } div_rsp_type;

endpackage

/* hdl/sldt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sldt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* hdl/sldt_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on sldt_pkg.
module sldt_div (
   input  logic                 clock,
   input  logic                 reset,
   input  sldt_pkg::div_req_type div_req,
   output sldt_pkg::div_rsp_type div_rsp
);
   import sldt_pkg::*;

   localparam int CNT_W = $clog2(HGT_W + 1);

   logic [HGT_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   trial_in;
   logic [DEN_W:0]   diff_in;

   always_comb begin
      trial_in = {rem_ff, quo_ff[HGT_W-1]};
      diff_in  = trial_in - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(HGT_W);
            quo_ff  <= div_req.num;
            den_ff  <= div_req.den;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            if (!diff_in[DEN_W]) begin
               rem_ff <= diff_in[DEN_W-1:0];
               quo_ff <= {quo_ff[HGT_W-2:0], 1'b1};
            end else begin
               rem_ff <= trial_in[DEN_W-1:0];
               quo_ff <= {quo_ff[HGT_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done   = done_ff;
   assign div_rsp.quo    = quo_ff;
   assign div_rsp.rem_nz = (rem_ff != '0);

`ifndef SYNTHESIS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without work");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0) else $error("divider count underflow");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff) else $error("divider restarted while busy");
`endif

endmodule

/* hdl/segmented_line_distance_transform.sv */
// After line_end is taken, each padded sample after the first goes through the envelope
// pass, where every vertex tried, popped or kept, costs a division in the 48-bit serial
// divider; the output pass then visits each padded sample.
// Load takes one cycle per voxel; requests stall while a line is processed.
// Reset (synchronous, active high) clears the load count, the controller and the
// response valid; voxel_size returns to 1.0 and edge_is_boundary to 0.
module segmented_line_distance_transform #(
   parameter int MAX_LINE = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [sldt_pkg::LABEL_W-1:0] req_region_label,
   input  logic [sldt_pkg::DIST_W-1:0]  req_dist_sq_in,
   input  logic                        req_line_end,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [sldt_pkg::DIST_W-1:0]  rsp_dist_sq_out,
   output logic                        rsp_last_out,
   input  logic                        csr_wr_en,
   input  logic [0:0]                  csr_index,
   input  logic [sldt_pkg::CSR_W-1:0]   csr_wr_data
);
   import sldt_pkg::*;

   localparam int AW  = $clog2(MAX_LINE);
   localparam int CW  = $clog2(MAX_LINE + 1);
   localparam int IW  = $clog2(MAX_LINE + 3);
   localparam int VAW = $clog2(MAX_LINE + 2);
   localparam int PW  = IW + VOX_W;

   typedef enum logic [4:0] {
      S_IDLE, S_RUN_RD, S_RUN_LAB, S_SCAN, S_SCAN_CMP, S_SETUP,
      S_QF_RD, S_QF, S_QH, S_VRD, S_VGET, S_PF_RD, S_PF, S_PH, S_DIV, S_CMP,
      S_OINIT, S_OQ, S_ORD, S_OADV, S_OVRD, S_OVGET, S_OF_RD, S_OF, S_OEMIT,
      S_H1, S_H2, S_H3
   } state_type;

   state_type state_ff, ret_ff;

   logic [VOX_W-1:0]   voxel_ff;
   logic               edge_ff;
   logic [CW-1:0]      load_cnt_ff;
   logic [CW-1:0]      len_ff;
   logic [AW-1:0]      idx_ff, e_ff;
   logic [LABEL_W-1:0] lab_ff;
   logic               has_l_ff;
   logic [IW-1:0]      np_ff, q_ff, k_ff, kmax_ff, p_ff, v_ff, hj_ff;
   logic [DIST_W-1:0]  hf_ff;
   logic [PW-1:0]      hpos_ff;
   logic [2*PW-1:0]    hsq_ff;
   logic [HGT_W-1:0]   hres_ff, hq_ff;
   logic [PW-1:0]      qd_ff;
   logic               neg_ff;
   logic [HGT_W-1:0]   s_ff;
   logic               rsp_valid_ff;
   logic [DIST_W-1:0]  rsp_dist_ff;
   logic               rsp_last_ff;

   logic [VOX_W-1:0]   d_eff;
   logic               req_take;
   logic               emit_now;
   logic               edge_now, has_l_now, has_r_now;
   logic [IW-1:0]      np_now;
   logic [HGT_W-1:0]   num_in, mag_in, quo_signed;
   logic [DEN_W-2:0]   den_half;
   logic [HGT_W-1:0]   tot_in;
   logic [IW:0]        m_q;
   logic [IW:0]        dist_pos;
   logic [IW-1:0]      dist_j, gap_in;

   logic [AW-1:0]      lab_rd_addr, dist_rd_addr;
   logic [LABEL_W-1:0] lab_rd;
   logic [DIST_W-1:0]  dist_rd;
   logic               vert_we, cross_we;
   logic [VAW-1:0]     vert_wa, vert_ra;
   logic [IW-1:0]      vert_wd, vert_rd;
   logic [IW-1:0]      cross_wa, cross_ra;
   logic [HGT_W-1:0]   cross_rd;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   function automatic logic [IW:0] line_pos(input logic [IW-1:0] j);
      line_pos = (IW+1)'(idx_ff) + (IW+1)'(j) - (IW+1)'(has_l_ff);
   endfunction

   function automatic logic in_run(input logic [IW-1:0] j);
      logic [IW:0] m;
      m = line_pos(j);
      in_run = !(has_l_ff && j == '0) && (m <= (IW+1)'(e_ff));
   endfunction

   always_comb begin
      d_eff     = (voxel_ff == '0) ? VOX_W'(1) : voxel_ff;
      req_stall = (state_ff != S_IDLE);
      req_take  = req_valid && !req_stall;
      emit_now  = (state_ff == S_OEMIT) && in_run(q_ff) && (!rsp_valid_ff || !rsp_stall);
      edge_now  = edge_ff && (lab_ff != '0);
      has_l_now = (idx_ff != '0) || edge_now;
      has_r_now = ((CW+1)'(e_ff) + (CW+1)'(1) < (CW+1)'(len_ff)) || edge_now;
      np_now    = IW'(e_ff) - IW'(idx_ff) + IW'(1) + IW'(has_l_now) + IW'(has_r_now);
      num_in    = hq_ff - hres_ff;
      mag_in    = num_in[HGT_W-1] ? (HGT_W'(0) - num_in) : num_in;
      den_half  = (DEN_W-1)'(d_eff) * (DEN_W-1)'(q_ff - p_ff);
      quo_signed = neg_ff ? (HGT_W'(0) - div_rsp.quo - HGT_W'(div_rsp.rem_nz))
                          : div_rsp.quo;
      tot_in    = (hres_ff + HGT_W'(128)) >> 8;
      m_q       = line_pos(q_ff);
      gap_in    = (q_ff >= v_ff) ? (q_ff - v_ff) : (v_ff - q_ff);

      unique case (state_ff)
         S_PF_RD: dist_j = p_ff;
         S_OF_RD: dist_j = v_ff;
         default: dist_j = q_ff;
      endcase
      dist_pos     = line_pos(dist_j);
      dist_rd_addr = dist_pos[AW-1:0];

      priority case (state_ff)
         S_RUN_RD: lab_rd_addr = idx_ff;
         default:  lab_rd_addr = AW'((CW+1)'(e_ff) + (CW+1)'(1));
      endcase

      vert_ra = k_ff[VAW-1:0];
      if (state_ff == S_OQ || state_ff == S_ORD || state_ff == S_OADV) begin
         cross_ra = k_ff + IW'(1);
      end else begin
         cross_ra = k_ff;
      end

      vert_we  = (state_ff == S_SETUP) || (state_ff == S_CMP && !(k_ff != '0 &&
                 $signed(s_ff) <= $signed(cross_rd)));
      vert_wa  = (state_ff == S_SETUP) ? '0 : VAW'(k_ff + IW'(1));
      vert_wd  = (state_ff == S_SETUP) ? '0 : q_ff;
      cross_we = (state_ff == S_CMP) && vert_we;
      cross_wa = k_ff + IW'(1);

      div_req.start = (state_ff == S_PH);
      div_req.num   = mag_in;
      div_req.den   = {den_half, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         load_cnt_ff  <= '0;
         voxel_ff     <= VOX_RESET;
         edge_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_VOXEL_SIZE: voxel_ff <= csr_wr_data[VOX_W-1:0];
               CSR_EDGE_BOUND: edge_ff  <= csr_wr_data[0];
            endcase
         end
         if (rsp_valid_ff && !rsp_stall && !emit_now) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  if (req_line_end || load_cnt_ff + CW'(1) == CW'(MAX_LINE)) begin
                     len_ff      <= load_cnt_ff + CW'(1);
                     load_cnt_ff <= '0;
                     idx_ff      <= '0;
                     state_ff    <= S_RUN_RD;
                  end else begin
                     load_cnt_ff <= load_cnt_ff + CW'(1);
                  end
               end
            end
            S_RUN_RD: state_ff <= S_RUN_LAB;
            S_RUN_LAB: begin
               lab_ff <= lab_rd;
               e_ff   <= idx_ff;
               if ((CW+1)'(idx_ff) + (CW+1)'(1) < (CW+1)'(len_ff)) begin
                  state_ff <= S_SCAN;
               end else begin
                  state_ff <= S_SETUP;
               end
            end
            S_SCAN: state_ff <= S_SCAN_CMP;
            S_SCAN_CMP: begin
               if (lab_rd == lab_ff) begin
                  e_ff <= e_ff + AW'(1);
                  if ((CW+1)'(e_ff) + (CW+1)'(2) < (CW+1)'(len_ff)) begin
                     state_ff <= S_SCAN;
                  end else begin
                     state_ff <= S_SETUP;
                  end
               end else begin
                  state_ff <= S_SETUP;
               end
            end
            S_SETUP: begin
               has_l_ff <= has_l_now;
               np_ff    <= np_now;
               k_ff     <= '0;
               kmax_ff  <= '0;
               q_ff     <= IW'(1);
               state_ff <= (np_now == IW'(1)) ? S_OINIT : S_QF_RD;
            end
            S_QF_RD: state_ff <= S_QF;
            S_QF: begin
               hj_ff    <= q_ff;
               hf_ff    <= in_run(q_ff) ? dist_rd : '0;
               ret_ff   <= S_QH;
               state_ff <= S_H1;
            end
            S_QH: begin
               hq_ff    <= hres_ff;
               state_ff <= S_VRD;
            end
            S_VRD: state_ff <= S_VGET;
            S_VGET: begin
               p_ff     <= vert_rd;
               state_ff <= S_PF_RD;
            end
            S_PF_RD: state_ff <= S_PF;
            S_PF: begin
               hj_ff    <= p_ff;
               hf_ff    <= in_run(p_ff) ? dist_rd : '0;
               ret_ff   <= S_PH;
               state_ff <= S_H1;
            end
            S_PH: begin
               neg_ff   <= num_in[HGT_W-1];
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (div_rsp.done) begin
                  s_ff     <= quo_signed;
                  state_ff <= S_CMP;
               end
            end
            S_CMP: begin
               if (k_ff != '0 && $signed(s_ff) <= $signed(cross_rd)) begin
                  k_ff     <= k_ff - IW'(1);
                  state_ff <= S_VRD;
               end else begin
                  k_ff <= k_ff + IW'(1);
                  q_ff <= q_ff + IW'(1);
                  if (q_ff + IW'(1) < np_ff) begin
                     state_ff <= S_QF_RD;
                  end else begin
                     kmax_ff  <= k_ff + IW'(1);
                     state_ff <= S_OINIT;
                  end
               end
            end
            S_OINIT: begin
               k_ff     <= '0;
               q_ff     <= '0;
               state_ff <= S_OQ;
            end
            S_OQ: begin
               qd_ff    <= PW'(q_ff) * PW'(d_eff);
               state_ff <= S_OADV;
            end
            S_ORD: state_ff <= S_OADV;
            S_OADV: begin
               if (k_ff < kmax_ff && $signed(cross_rd) < $signed(HGT_W'(qd_ff))) begin
                  k_ff     <= k_ff + IW'(1);
                  state_ff <= S_ORD;
               end else begin
                  state_ff <= S_OVRD;
               end
            end
            S_OVRD: state_ff <= S_OVGET;
            S_OVGET: begin
               v_ff     <= vert_rd;
               state_ff <= S_OF_RD;
            end
            S_OF_RD: state_ff <= S_OF;
            S_OF: begin
               hj_ff    <= gap_in;
               hf_ff    <= in_run(v_ff) ? dist_rd : '0;
               ret_ff   <= S_OEMIT;
               state_ff <= S_H1;
            end
            S_OEMIT: begin
               if (!in_run(q_ff) || !rsp_valid_ff || !rsp_stall) begin
                  if (in_run(q_ff)) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_dist_ff  <= (tot_in[HGT_W-1:DIST_W] != '0) ? DIST_INF
                                                                  : tot_in[DIST_W-1:0];
                     rsp_last_ff  <= (m_q == (IW+1)'(len_ff) - (IW+1)'(1));
                  end
                  if (q_ff + IW'(1) < np_ff) begin
                     q_ff     <= q_ff + IW'(1);
                     state_ff <= S_OQ;
                  end else if ((CW+1)'(e_ff) + (CW+1)'(1) < (CW+1)'(len_ff)) begin
                     idx_ff   <= e_ff + AW'(1);
                     state_ff <= S_RUN_RD;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_H1: begin
               hpos_ff  <= PW'(hj_ff) * PW'(d_eff);
               state_ff <= S_H2;
            end
            S_H2: begin
               hsq_ff   <= (2*PW)'(hpos_ff) * (2*PW)'(hpos_ff);
               state_ff <= S_H3;
            end
            S_H3: begin
               hres_ff  <= (HGT_W'(hf_ff) << 8) + HGT_W'(hsq_ff);
               state_ff <= ret_ff;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_dist_sq_out = rsp_dist_ff;
   assign rsp_last_out    = rsp_last_ff;

   sldt_ram #(.WIDTH(LABEL_W), .DEPTH(MAX_LINE)) u_label_ram (
      .clock   (clock),
      .wr_en   (req_take),
      .wr_addr (load_cnt_ff[AW-1:0]),
      .wr_data (req_region_label),
      .rd_addr (lab_rd_addr),
      .rd_data (lab_rd)
   );

   sldt_ram #(.WIDTH(DIST_W), .DEPTH(MAX_LINE)) u_dist_ram (
      .clock   (clock),
      .wr_en   (req_take),
      .wr_addr (load_cnt_ff[AW-1:0]),
      .wr_data (req_dist_sq_in),
      .rd_addr (dist_rd_addr),
      .rd_data (dist_rd)
   );

   sldt_ram #(.WIDTH(IW), .DEPTH(MAX_LINE + 2)) u_vertex_ram (
      .clock   (clock),
      .wr_en   (vert_we),
      .wr_addr (vert_wa),
      .wr_data (vert_wd),
      .rd_addr (vert_ra),
      .rd_data (vert_rd)
   );

   sldt_ram #(.WIDTH(HGT_W), .DEPTH(MAX_LINE + 3)) u_cross_ram (
      .clock   (clock),
      .wr_en   (cross_we),
      .wr_addr (cross_wa),
      .wr_data (s_ff),
      .rd_addr (cross_ra),
      .rd_data (cross_rd)
   );

   sldt_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

`ifndef SYNTHESIS
   a_load_range: assert property (@(posedge clock) disable iff (reset)
      load_cnt_ff < CW'(MAX_LINE)) else $error("load count out of range");
   a_k_below_q: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CMP |-> k_ff < q_ff) else $error("envelope index past sample");
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OEMIT))
      else $error("response raised outside emit");
   a_div_return: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV && div_rsp.done |=> state_ff == S_CMP)
      else $error("divider result not consumed");
`endif

endmodule
